// ===== hdl/bpfa_pkg.sv =====
// Shared types, constants and request codes of the bitmap page frame allocator.
package bpfa_pkg;

  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;
  localparam int PAGE_SHIFT    = 12;
  localparam int WORD_SHIFT    = 17;
  localparam int WORD_IDX_W    = 15;
  localparam int MAP_WORDS_DEF = 32768;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;

  localparam logic [1:0] BU_FIND = 2'd0;
  localparam logic [1:0] BU_SET  = 2'd1;
  localparam logic [1:0] BU_CLR  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] page_addr;
  } bpfa_req_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] alloc_addr;
  } bpfa_rsp_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [WORD_BITS-1:0] word;
    logic [BIT_W-1:0]     sel;
  } bpfa_bu_req_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     idx;
    logic [WORD_BITS-1:0] word;
    logic                 nz;
  } bpfa_bu_rsp_t;

endpackage

// ===== hdl/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap page frame allocator: sequencer, free map and summaries.
//
//   Port group   Dir   Payload       Handshake
//   in_          in    bpfa_req_t    in_valid / in_stall
//   out_         out   bpfa_rsp_t    out_valid / out_stall
//
// An allocate runs A3, A2, A1R, A1, A0R, A0, U1, U2, U3, DONE (A3 goes to DONE
// when no page is free), a free or a mark-used runs MR, M0, U1, U2, U3, DONE,
// and an unknown type, or a free or mark-used beyond the map, goes to DONE. The
// steps follow the single shared bit unit, used once per level on the way down
// and once per summary level on the way back up, and the registered read port
// of each map memory. Reset clears only the two upper summary levels, which
// live in flip-flops; the middle summary and the map words are trusted only
// where the level above marks them nonzero, so no clearing pass is needed.
// A new request is taken whenever the sequencer is idle, even while a result
// still waits in the output register; the sequencer then holds its finished
// result until that register is free.
module bitmap_page_frame_allocator #(
  parameter int MAP_WORDS = bpfa_pkg::MAP_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpfa_pkg::bpfa_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bpfa_pkg::bpfa_rsp_t out_data
);
  import bpfa_pkg::*;

  // Three-level hierarchy: each bit of a level says whether the word it covers
  // one level down has any free page.
  localparam int L1_DEPTH = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int L2_DEPTH = (L1_DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int W0 = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int W1 = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
  localparam int W2 = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_A3   = 4'd1;
  localparam logic [3:0] S_A2   = 4'd2;
  localparam logic [3:0] S_A1R  = 4'd3;
  localparam logic [3:0] S_A1   = 4'd4;
  localparam logic [3:0] S_A0R  = 4'd5;
  localparam logic [3:0] S_A0   = 4'd6;
  localparam logic [3:0] S_MR   = 4'd7;
  localparam logic [3:0] S_M0   = 4'd8;
  localparam logic [3:0] S_U1   = 4'd9;
  localparam logic [3:0] S_U2   = 4'd10;
  localparam logic [3:0] S_U3   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]            state_r, state_nxt;
  logic [1:0]            type_r, type_nxt;
  logic [WORD_IDX_W-1:0] word_r, word_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic                  grant_r, grant_nxt;
  logic                  nz_r, nz_nxt;
  logic [WORD_BITS-1:0]  w1_r, w1_nxt;
  logic [WORD_BITS-1:0]  rd0_r, rd1_r;
  logic [WORD_BITS-1:0]  sum2_r [L2_DEPTH];
  logic [L2_DEPTH-1:0]   sum3_r;
  logic                  out_valid_r, out_valid_nxt;
  bpfa_rsp_t             out_data_r, out_data_nxt;

  // The free map and the middle summary level.
  logic [WORD_BITS-1:0]  mem0 [MAP_WORDS];
  logic [WORD_BITS-1:0]  mem1 [L1_DEPTH];

  logic [W0-1:0]         a0;
  logic [W1-1:0]         a1;
  logic [W2-1:0]         i2;
  logic                  mem0_we, mem0_re, mem1_we, mem1_re;
  logic                  in_range;
  logic                  in_acc;
  logic                  out_free;
  logic [WORD_BITS-1:0]  eff1, eff0;
  bpfa_bu_req_t          bu_req;
  bpfa_bu_rsp_t          bu_rsp;

  assign a0 = word_r[W0-1:0];
  assign a1 = word_r[W1+BIT_W-1:BIT_W];
  assign i2 = word_r[W2+2*BIT_W-1:2*BIT_W];

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_range = ({1'b0, in_data.page_addr[31:WORD_SHIFT]} <
                     (WORD_IDX_W+1)'(MAP_WORDS));

  // The middle summary word counts only when its top-level bit is set, and a
  // map word only when its middle summary bit is set.
  assign eff1 = sum2_r[i2][word_r[2*BIT_W-1:BIT_W]] ? rd1_r : '0;
  assign eff0 = eff1[word_r[BIT_W-1:0]] ? rd0_r : '0;

  bpfa_bit_unit u_bit_unit (
    .req (bu_req),
    .rsp (bu_rsp)
  );

  // Operand selection for the shared bit unit.
  always_comb begin
    bu_req.op   = BU_FIND;
    bu_req.word = '0;
    bu_req.sel  = '0;
    unique case (state_r)
      S_A3: begin
        bu_req.word = WORD_BITS'(sum3_r);
      end
      S_A2: begin
        bu_req.word = sum2_r[i2];
      end
      S_A1: begin
        bu_req.word = rd1_r;
      end
      S_A0: begin
        bu_req.word = rd0_r;
      end
      S_M0: begin
        bu_req.op   = (type_r == REQ_FREE) ? BU_SET : BU_CLR;
        bu_req.word = eff0;
        bu_req.sel  = bit_r;
      end
      S_U1: begin
        bu_req.op   = nz_r ? BU_SET : BU_CLR;
        bu_req.word = w1_r;
        bu_req.sel  = word_r[BIT_W-1:0];
      end
      S_U2: begin
        bu_req.op   = nz_r ? BU_SET : BU_CLR;
        bu_req.word = sum2_r[i2];
        bu_req.sel  = word_r[2*BIT_W-1:BIT_W];
      end
      S_U3: begin
        bu_req.op   = nz_r ? BU_SET : BU_CLR;
        bu_req.word = WORD_BITS'(sum3_r);
        bu_req.sel  = word_r[3*BIT_W-1:2*BIT_W];
      end
      default: begin
        bu_req.op = BU_FIND;
      end
    endcase
  end

  assign mem0_re = (state_r == S_A0R) || (state_r == S_MR);
  assign mem1_re = (state_r == S_A1R) || (state_r == S_MR);
  assign mem0_we = (state_r == S_A0) || (state_r == S_M0);
  assign mem1_we = (state_r == S_U1);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    type_nxt      = type_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    grant_nxt     = grant_r;
    nz_nxt        = nz_r;
    w1_nxt        = w1_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          type_nxt  = in_data.req_type;
          word_nxt  = in_data.page_addr[31:WORD_SHIFT];
          bit_nxt   = in_data.page_addr[WORD_SHIFT-1:PAGE_SHIFT];
          grant_nxt = 1'b0;
          if (in_data.req_type == REQ_ALLOC) begin
            state_nxt = S_A3;
          end else if ((in_data.req_type == REQ_FREE || in_data.req_type == REQ_MARK)
                       && in_range) begin
            state_nxt = S_MR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_A3: begin
        word_nxt[3*BIT_W-1:2*BIT_W] = bu_rsp.idx;
        state_nxt = bu_rsp.found ? S_A2 : S_DONE;
      end
      S_A2: begin
        word_nxt[2*BIT_W-1:BIT_W] = bu_rsp.idx;
        state_nxt = S_A1R;
      end
      S_A1R: begin
        state_nxt = S_A1;
      end
      S_A1: begin
        word_nxt[BIT_W-1:0] = bu_rsp.idx;
        w1_nxt    = rd1_r;
        state_nxt = S_A0R;
      end
      S_A0R: begin
        state_nxt = S_A0;
      end
      S_A0: begin
        bit_nxt   = bu_rsp.idx;
        nz_nxt    = bu_rsp.nz;
        grant_nxt = 1'b1;
        state_nxt = S_U1;
      end
      S_MR: begin
        state_nxt = S_M0;
      end
      S_M0: begin
        nz_nxt    = bu_rsp.nz;
        w1_nxt    = eff1;
        state_nxt = S_U1;
      end
      S_U1: begin
        nz_nxt    = bu_rsp.nz;
        state_nxt = S_U2;
      end
      S_U2: begin
        nz_nxt    = bu_rsp.nz;
        state_nxt = S_U3;
      end
      S_U3: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.granted    = grant_r;
          out_data_nxt.alloc_addr = grant_r ? {word_r, bit_r, {PAGE_SHIFT{1'b0}}} : '0;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum3_r      <= '0;
      for (int i = 0; i < L2_DEPTH; i++) begin
        sum2_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_U2) begin
        sum2_r[i2] <= bu_rsp.word;
      end
      if (state_r == S_U3) begin
        sum3_r <= bu_rsp.word[L2_DEPTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    type_r     <= type_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    grant_r    <= grant_nxt;
    nz_r       <= nz_nxt;
    w1_r       <= w1_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem0_we) begin
      mem0[a0] <= bu_rsp.word;
    end
    if (mem0_re) begin
      rd0_r <= mem0[a0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem1_we) begin
      mem1[a1] <= bu_rsp.word;
    end
    if (mem1_re) begin
      rd1_r <= mem1[a1];
    end
  end

  // A summary bit that leads the search down must point at a nonempty word.
  a_l2_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_A2 |-> sum2_r[i2] != '0)
    else $error("top summary points at an empty middle summary word");

  a_l1_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_A1 |-> rd1_r != '0)
    else $error("middle summary points at an empty summary word");

  a_l0_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_A0 |-> rd0_r != '0)
    else $error("summary points at a map word with no free page");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.granted |-> out_data_r.alloc_addr == '0)
    else $error("result without grant carries a nonzero address");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted request did not start the sequencer");

endmodule

// ===== hdl/bpfa_bit_unit.sv =====
// Shared bit unit: lowest-set-bit search with clear, and single bit set or clear.
module bpfa_bit_unit (
  input  bpfa_pkg::bpfa_bu_req_t req,
  output bpfa_pkg::bpfa_bu_rsp_t rsp
);
  import bpfa_pkg::*;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] res_word;
  logic [BIT_W-1:0]     low_idx;

  always_comb begin
    low_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (req.word[i]) begin
        low_idx = BIT_W'(i);
      end
    end
  end

  assign mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << req.sel;

  always_comb begin
    unique case (req.op)
      BU_FIND: res_word = req.word & (req.word - {{(WORD_BITS-1){1'b0}}, 1'b1});
      BU_SET:  res_word = req.word | mask;
      BU_CLR:  res_word = req.word & ~mask;
      default: res_word = req.word;
    endcase
  end

  assign rsp.found = |req.word;
  assign rsp.idx   = low_idx;
  assign rsp.word  = res_word;
  assign rsp.nz    = |res_word;

endmodule
